@@ rtl/assert_macros.svh @@
// Assertion macros for the encoder RTL file.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SWBE_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define SWBE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SWBE_ASSERT_IMPLY(lbl, ante, cons)
`define SWBE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/swbe_pkg.sv @@
// ----------------------------------------------------------------------------
// swbe_pkg
// Types, register map and microcode table of the single-wire backlight encoder.
// ----------------------------------------------------------------------------
package swbe_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_DEVICE_ADDRESS   = 3'd0;
    localparam logic [2:0] REG_SHORT_PHASE_US   = 3'd1;
    localparam logic [2:0] REG_LONG_PHASE_US    = 3'd2;
    localparam logic [2:0] REG_MARK_US          = 3'd3;
    localparam logic [2:0] REG_DETECT_DELAY_US  = 3'd4;
    localparam logic [2:0] REG_DETECT_LOW_US    = 3'd5;
    localparam logic [2:0] REG_DETECT_WINDOW_US = 3'd6;
    localparam logic [2:0] REG_SHUTDOWN_US      = 3'd7;

    // Register reset values
    localparam logic [7:0]  RST_DEVICE_ADDRESS   = 8'h72;
    localparam logic [7:0]  RST_SHORT_PHASE_US   = 8'd4;
    localparam logic [7:0]  RST_LONG_PHASE_US    = 8'd8;
    localparam logic [7:0]  RST_MARK_US          = 8'd4;
    localparam logic [15:0] RST_DETECT_DELAY_US  = 16'd200;
    localparam logic [15:0] RST_DETECT_LOW_US    = 16'd500;
    localparam logic [15:0] RST_DETECT_WINDOW_US = 16'd1000;
    localparam logic [15:0] RST_SHUTDOWN_US      = 16'd5000;

    // Sequencer steps
    typedef enum logic [3:0] {
        ST_SHUT   = 4'd0,
        ST_DET1   = 4'd1,
        ST_DET2   = 4'd2,
        ST_DET3   = 4'd3,
        ST_MARK_A = 4'd4,
        ST_ABIT0  = 4'd5,
        ST_ABIT1  = 4'd6,
        ST_END_A  = 4'd7,
        ST_MARK_D = 4'd8,
        ST_DBIT0  = 4'd9,
        ST_DBIT1  = 4'd10,
        ST_END_D  = 4'd11,
        ST_HOLD   = 4'd12
    } step_t;

    // Duration source of a segment
    typedef enum logic [2:0] {
        DUR_DET_DELAY,
        DUR_DET_LOW,
        DUR_DET_WIN,
        DUR_MARK,
        DUR_BIT_A,
        DUR_BIT_B,
        DUR_SHUTDOWN,
        DUR_ZERO
    } dur_sel_t;

    // Sequencing operation
    typedef enum logic [1:0] {
        OP_NEXT,
        OP_LOOP,
        OP_END
    } uop_t;

    typedef struct packed {
        logic     pin;
        dur_sel_t dur;
        logic     last;
        uop_t     op;
        step_t    nxt;
        step_t    jmp;
        logic     set_en;
        logic     clr_en;
        logic     ld_addr;
        logic     ld_data;
    } uword_t;

    // Control store: one word per step
    function automatic uword_t ucode(step_t s);
        uword_t w;
        w = '{pin: 1'b0, dur: DUR_ZERO, last: 1'b0, op: OP_NEXT, nxt: ST_SHUT,
              jmp: ST_SHUT, set_en: 1'b0, clr_en: 1'b0, ld_addr: 1'b0, ld_data: 1'b0};
        case (s)
            ST_SHUT:
            begin
                w.dur = DUR_SHUTDOWN; w.last = 1'b1; w.op = OP_END; w.clr_en = 1'b1;
            end
            ST_DET1:   begin w.pin = 1'b1; w.dur = DUR_DET_DELAY; w.nxt = ST_DET2; end
            ST_DET2:   begin w.dur = DUR_DET_LOW; w.nxt = ST_DET3; end
            ST_DET3:
            begin
                w.pin = 1'b1; w.dur = DUR_DET_WIN; w.nxt = ST_MARK_A; w.set_en = 1'b1;
            end
            ST_MARK_A:
            begin
                w.pin = 1'b1; w.dur = DUR_MARK; w.nxt = ST_ABIT0; w.ld_addr = 1'b1;
            end
            ST_ABIT0:  begin w.dur = DUR_BIT_A; w.nxt = ST_ABIT1; end
            ST_ABIT1:
            begin
                w.pin = 1'b1; w.dur = DUR_BIT_B; w.op = OP_LOOP;
                w.nxt = ST_END_A; w.jmp = ST_ABIT0;
            end
            ST_END_A:  begin w.dur = DUR_MARK; w.nxt = ST_MARK_D; end
            ST_MARK_D:
            begin
                w.pin = 1'b1; w.dur = DUR_MARK; w.nxt = ST_DBIT0; w.ld_data = 1'b1;
            end
            ST_DBIT0:  begin w.dur = DUR_BIT_A; w.nxt = ST_DBIT1; end
            ST_DBIT1:
            begin
                w.pin = 1'b1; w.dur = DUR_BIT_B; w.op = OP_LOOP;
                w.nxt = ST_END_D; w.jmp = ST_DBIT0;
            end
            ST_END_D:  begin w.dur = DUR_MARK; w.nxt = ST_HOLD; end
            ST_HOLD:
            begin
                w.pin = 1'b1; w.dur = DUR_ZERO; w.last = 1'b1; w.op = OP_END;
            end
            default:   begin w.op = OP_END; w.last = 1'b1; end
        endcase
        return w;
    endfunction

endpackage

@@ rtl/single_wire_backlight_encoder.sv @@
// ----------------------------------------------------------------------------
// single_wire_backlight_encoder
// A taken request is registered into the step and busy registers; its first segment then
//   goes out through the output register. Throughput: one segment per cycle while the
//   segment channel does not stall; a request holds the input for one step per segment
//   plus the accept cycle, longer while the segment channel stalls.
// Reset: rst_n async low; config registers return to defaults, line marked not enabled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module single_wire_backlight_encoder
    import swbe_pkg::*;
#(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  level,
    // segment channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        pin_level,
    output logic [15:0] duration_us,
    output logic        last
);

    // Shift store is wide enough for either field; bit counter indexes it.
    localparam int SW    = (ADDR_BITS > DATA_BITS) ? ADDR_BITS : DATA_BITS;
    localparam int CNT_W = (SW > 1) ? $clog2(SW) : 1;

    // Configuration registers
    logic [7:0]  device_address_reg;
    logic [7:0]  short_phase_reg;
    logic [7:0]  long_phase_reg;
    logic [7:0]  mark_reg;
    logic [15:0] detect_delay_reg;
    logic [15:0] detect_low_reg;
    logic [15:0] detect_window_reg;
    logic [15:0] shutdown_reg;

    // Sequencer state
    logic             busy_reg,    busy_next;
    step_t            step_reg,    step_next;
    logic [CNT_W-1:0] cnt_reg,     cnt_next;
    logic [SW-1:0]    sreg_reg,    sreg_next;
    logic [7:0]       level_reg,   level_next;
    logic             enabled_reg, enabled_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic        pin_reg,       pin_next;
    logic [15:0] dur_reg,       dur_next;
    logic        last_reg,      last_next;

    uword_t           uword;
    logic             accept;
    logic             emit;
    logic             cur_bit;
    logic [SW+7:0]    addr_wide;
    logic [SW+7:0]    data_wide;
    logic [15:0]      seg_dur;

    // Configuration writes; all eight indexes map to a register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= RST_DEVICE_ADDRESS;
            short_phase_reg    <= RST_SHORT_PHASE_US;
            long_phase_reg     <= RST_LONG_PHASE_US;
            mark_reg           <= RST_MARK_US;
            detect_delay_reg   <= RST_DETECT_DELAY_US;
            detect_low_reg     <= RST_DETECT_LOW_US;
            detect_window_reg  <= RST_DETECT_WINDOW_US;
            shutdown_reg       <= RST_SHUTDOWN_US;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DEVICE_ADDRESS:   device_address_reg <= cfg_wdata[7:0];
                REG_SHORT_PHASE_US:   short_phase_reg    <= cfg_wdata[7:0];
                REG_LONG_PHASE_US:    long_phase_reg     <= cfg_wdata[7:0];
                REG_MARK_US:          mark_reg           <= cfg_wdata[7:0];
                REG_DETECT_DELAY_US:  detect_delay_reg   <= cfg_wdata;
                REG_DETECT_LOW_US:    detect_low_reg     <= cfg_wdata;
                REG_DETECT_WINDOW_US: detect_window_reg  <= cfg_wdata;
                REG_SHUTDOWN_US:      shutdown_reg       <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    // Fetch the control word of the current step.
    assign uword = ucode(step_reg);

    // Zero-extend or truncate the 8-bit fields to the shift width; bits above
    // the field's width go out as 0.
    assign addr_wide = {{SW{1'b0}}, device_address_reg};
    assign data_wide = {{SW{1'b0}}, level_reg};

    // Current bit, MSB first: the counter counts down from the field width minus one.
    assign cur_bit = sreg_reg[cnt_reg];

    // Pick the segment duration.
    always_comb
    begin
        case (uword.dur)
            DUR_DET_DELAY: seg_dur = detect_delay_reg;
            DUR_DET_LOW:   seg_dur = detect_low_reg;
            DUR_DET_WIN:   seg_dur = detect_window_reg;
            DUR_MARK:      seg_dur = {8'd0, mark_reg};
            DUR_BIT_A:     seg_dur = {8'd0, cur_bit ? short_phase_reg : long_phase_reg};
            DUR_BIT_B:     seg_dur = {8'd0, cur_bit ? long_phase_reg : short_phase_reg};
            DUR_SHUTDOWN:  seg_dur = shutdown_reg;
            DUR_ZERO:      seg_dur = 16'd0;
            default:       seg_dur = 16'd0;
        endcase
    end

    // Take a new request only when the sequencer is idle; while busy, advance one step
    // whenever the output register is empty or being drained.
    assign accept = in_valid && !busy_reg;
    assign emit   = busy_reg && (!out_valid_reg || !out_stall);

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        sreg_next      = sreg_reg;
        level_next     = level_reg;
        enabled_next   = enabled_reg;
        out_valid_next = out_valid_reg;
        pin_next       = pin_reg;
        dur_next       = dur_reg;
        last_next      = last_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            busy_next  = 1'b1;
            level_next = level;
            if (level == 8'd0)
            begin
                step_next = ST_SHUT;
            end
            else if (enabled_reg)
            begin
                step_next = ST_MARK_A;
            end
            else
            begin
                step_next = ST_DET1;
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            pin_next       = uword.pin;
            dur_next       = seg_dur;
            last_next      = uword.last;

            if (uword.set_en)
            begin
                enabled_next = 1'b1;
            end
            if (uword.clr_en)
            begin
                enabled_next = 1'b0;
            end
            if (uword.ld_addr)
            begin
                sreg_next = addr_wide[SW-1:0];
                cnt_next  = CNT_W'(ADDR_BITS - 1);
            end
            if (uword.ld_data)
            begin
                sreg_next = data_wide[SW-1:0];
                cnt_next  = CNT_W'(DATA_BITS - 1);
            end

            case (uword.op)
                OP_NEXT:
                begin
                    step_next = uword.nxt;
                end
                OP_LOOP:
                begin
                    // Loop back for the next bit until the counter runs out.
                    if (cnt_reg != '0)
                    begin
                        cnt_next  = cnt_reg - 1'b1;
                        step_next = uword.jmp;
                    end
                    else
                    begin
                        step_next = uword.nxt;
                    end
                end
                OP_END:
                begin
                    busy_next = 1'b0;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= ST_SHUT;
            enabled_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            enabled_reg   <= enabled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        sreg_reg  <= sreg_next;
        level_reg <= level_next;
        pin_reg   <= pin_next;
        dur_reg   <= dur_next;
        last_reg  <= last_next;
    end

    assign in_stall    = busy_reg;
    assign out_valid   = out_valid_reg;
    assign pin_level   = pin_reg;
    assign duration_us = dur_reg;
    assign last        = last_reg;

    // A taken request always starts the sequencer.
    `SWBE_ASSERT_NEXT(a_accept_starts, accept, busy_reg)
    // Shutdown drops the enabled flag.
    `SWBE_ASSERT_NEXT(a_shut_clears, emit && step_reg == ST_SHUT, !enabled_reg)
    // The end of the preamble marks the line enabled.
    `SWBE_ASSERT_NEXT(a_detect_sets, emit && step_reg == ST_DET3, enabled_reg)
    // The address loop exits to the end mark once the counter is spent.
    `SWBE_ASSERT_NEXT(a_addr_loop_exit, emit && step_reg == ST_ABIT1 && cnt_reg == '0,
        step_reg == ST_END_A)
    // A segment marked last never comes from a step in mid-frame.
    `SWBE_ASSERT_IMPLY(a_last_only_at_end, emit && uword.last, uword.op == OP_END)

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: single-wire backlight encoder testbench
// Sends backlight level requests and register settings to the encoder and
// checks every pin segment it emits against a local model of the one-wire
// framing: enable preamble, address and level bytes, marks and shutdown.
// ----------------------------------------------------------------------------
module tb_top
    import swbe_pkg::*;
();

    localparam int ADDR_BITS   = 8;
    localparam int DATA_BITS   = 8;
    localparam int CYCLE_LIMIT = 1_500_000;

    // Register indexes in map order, used for bulk writes.
    localparam logic [2:0] REG_LIST [8] = '{
        REG_DEVICE_ADDRESS, REG_SHORT_PHASE_US, REG_LONG_PHASE_US, REG_MARK_US,
        REG_DETECT_DELAY_US, REG_DETECT_LOW_US, REG_DETECT_WINDOW_US, REG_SHUTDOWN_US
    };

    // One pin segment as it leaves the encoder.
    typedef struct {
        logic        pin;
        logic [15:0] dur;
        logic        fin;
    } segment_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  level;
    logic        out_valid;
    logic        out_stall;
    logic        pin_level;
    logic [15:0] duration_us;
    logic        last;

    // Local copy of the encoder registers and line state.
    logic [7:0]  dev_addr;
    logic [7:0]  short_us;
    logic [7:0]  long_us;
    logic [7:0]  mark_len;
    logic [15:0] det_delay;
    logic [15:0] det_low;
    logic [15:0] det_window;
    logic [15:0] shut_len;
    logic        line_on;

    segment_t    pending_segments[$];
    int          errors;
    int          cycle_count;
    bit          quiet;     // when set, neither side idles or stalls

    single_wire_backlight_encoder #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .level       (level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pin_level   (pin_level),
        .duration_us (duration_us),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Mostly short pauses, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Segment model
    // ------------------------------------------------------------------------
    function automatic void push_segment(input logic pin, input logic [15:0] dur,
                                         input logic fin);
        segment_t s;
        s.pin = pin;
        s.dur = dur;
        s.fin = fin;
        pending_segments.push_back(s);
    endfunction

    // MSB first; a 1 is short low + long high, a 0 is long low + short high.
    // Bit positions past the 8-bit value go out as 0.
    function automatic void push_byte_bits(input logic [7:0] value, input int nbits);
        logic b;
        for (int k = nbits - 1; k >= 0; k--)
        begin
            b = (k < 8) ? value[k] : 1'b0;
            if (b)
            begin
                push_segment(1'b0, {8'd0, short_us}, 1'b0);
                push_segment(1'b1, {8'd0, long_us}, 1'b0);
            end
            else
            begin
                push_segment(1'b0, {8'd0, long_us}, 1'b0);
                push_segment(1'b1, {8'd0, short_us}, 1'b0);
            end
        end
    endfunction

    // Append every segment that one accepted level request produces.
    function automatic void encode_level(input logic [7:0] lvl);
        if (lvl == 8'd0)
        begin
            // shutdown: one long low, line needs the preamble again
            push_segment(1'b0, shut_len, 1'b1);
            line_on = 1'b0;
            return;
        end
        if (!line_on)
        begin
            push_segment(1'b1, det_delay, 1'b0);
            push_segment(1'b0, det_low, 1'b0);
            push_segment(1'b1, det_window, 1'b0);
            line_on = 1'b1;
        end
        push_segment(1'b1, {8'd0, mark_len}, 1'b0);
        push_byte_bits(dev_addr, ADDR_BITS);
        push_segment(1'b0, {8'd0, mark_len}, 1'b0);
        push_segment(1'b1, {8'd0, mark_len}, 1'b0);
        push_byte_bits(lvl, DATA_BITS);
        push_segment(1'b0, {8'd0, mark_len}, 1'b0);
        // final high hold, open-ended
        push_segment(1'b1, 16'd0, 1'b1);
    endfunction

    function automatic void reset_registers();
        dev_addr   = RST_DEVICE_ADDRESS;
        short_us   = RST_SHORT_PHASE_US;
        long_us    = RST_LONG_PHASE_US;
        mark_len   = RST_MARK_US;
        det_delay  = RST_DETECT_DELAY_US;
        det_low    = RST_DETECT_LOW_US;
        det_window = RST_DETECT_WINDOW_US;
        shut_len   = RST_SHUTDOWN_US;
        line_on    = 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Write one register; 8-bit registers keep only the low byte.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            REG_DEVICE_ADDRESS:   dev_addr   = val[7:0];
            REG_SHORT_PHASE_US:   short_us   = val[7:0];
            REG_LONG_PHASE_US:    long_us    = val[7:0];
            REG_MARK_US:          mark_len   = val[7:0];
            REG_DETECT_DELAY_US:  det_delay  = val;
            REG_DETECT_LOW_US:    det_low    = val;
            REG_DETECT_WINDOW_US: det_window = val;
            REG_SHUTDOWN_US:      shut_len   = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic write_all(input logic [15:0] val);
        foreach (REG_LIST[i])
            write_reg(REG_LIST[i], val);
    endtask

    // Offer one level request, hold it until taken, then predict its segments.
    // Valid stays high afterwards so that back-to-back requests are possible.
    task automatic send_level(input logic [7:0] lvl);
        int gap;
        gap = quiet ? 0 : idle_length();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            level    = 8'($urandom_range(0, 255));
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        level    = lvl;
        do
            @(posedge clk);
        while (in_stall);
        encode_level(lvl);
    endtask

    // Drop the request line and hold until every predicted segment is out.
    task automatic settle_block();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_segments.size() != 0)
            @(posedge clk);
    endtask

    // Random back-pressure on the segment channel.
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = quiet ? 0 : idle_length();
            @(negedge clk);
            out_stall = (n > 0);
            if (n > 1)
                repeat (n - 1) @(negedge clk);
        end
    end

    // Compare each segment taken from the encoder with the oldest prediction.
    always @(posedge clk)
    begin
        segment_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_segments.size() == 0)
            begin
                $display("%0t: unexpected segment pin_level=%0d duration_us=%0d last=%0d",
                         $time, pin_level, duration_us, last);
                errors++;
            end
            else
            begin
                want = pending_segments.pop_front();
                if (pin_level !== want.pin)
                begin
                    $display("%0t: pin_level expected %0d actual %0d",
                             $time, want.pin, pin_level);
                    errors++;
                end
                if (duration_us !== want.dur)
                begin
                    $display("%0t: duration_us expected %0d actual %0d",
                             $time, want.dur, duration_us);
                    errors++;
                end
                if (last !== want.fin)
                begin
                    $display("%0t: last expected %0d actual %0d",
                             $time, want.fin, last);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values: preamble on first use, bit patterns, repeated shutdown,
    // re-enable after shutdown, and back-to-back requests with no idling.
    task automatic test_reset_defaults();
        send_level(8'h01);
        send_level(8'hFF);
        send_level(8'h80);
        send_level(8'h55);
        send_level(8'hAA);
        send_level(8'h00);
        send_level(8'h00);
        send_level(8'h7F);
        quiet = 1'b1;
        send_level(8'h00);
        send_level(8'h01);
        send_level(8'h00);
        send_level(8'hFE);
        settle_block();
        quiet = 1'b0;
    endtask

    // Register extremes: all ones (8-bit registers drop the upper byte),
    // all zero timing, and all durations set to one.
    task automatic test_register_extremes();
        write_all(16'hFFFF);
        send_level(8'hFF);
        send_level(8'h00);
        send_level(8'h01);
        settle_block();
        write_all(16'h0000);
        send_level(8'h5A);
        send_level(8'h00);
        send_level(8'hA5);
        settle_block();
        write_all(16'h0001);
        send_level(8'h80);
        send_level(8'h00);
        settle_block();
    endtask

    // Random levels under several random register settings.
    task automatic test_random_traffic();
        logic [7:0] lvl;
        for (int phase = 0; phase < 5; phase++)
        begin
            // the first phase runs without any idling
            quiet = (phase == 0);
            foreach (REG_LIST[i])
                write_reg(REG_LIST[i], ($urandom_range(0, 9) == 0) ? 16'd0
                                       : 16'($urandom_range(0, 65535)));
            for (int n = 0; n < 18; n++)
            begin
                lvl = ($urandom_range(0, 99) < 15) ? 8'd0 : 8'($urandom_range(1, 255));
                // now and then wait for the line to go quiet before the next request
                if (n == 9 || $urandom_range(0, 19) == 0)
                    settle_block();
                send_level(lvl);
            end
            settle_block();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_DEVICE_ADDRESS;
        cfg_wdata   = 16'd0;
        in_valid    = 1'b0;
        level       = 8'd0;
        errors      = 0;
        cycle_count = 0;
        quiet       = 1'b0;
        reset_registers();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_random_traffic();

        // drain, then watch a little longer for stray segments
        settle_block();
        repeat (20) @(posedge clk);
        if (pending_segments.size() != 0)
            $display("%0t: %0d predicted segments never arrived",
                     $time, pending_segments.size());
        if (errors == 0 && pending_segments.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
